@@ hw/rtl/phc_pkg.sv @@
// ----------------------------------------------------------------------------
// phc_pkg
// Shared constants, types and the arctangent table of the pursuit controller.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMax = 24;

  localparam int unsigned PosW  = 16;
  localparam int unsigned AngW  = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned LinW  = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // CORDIC datapath width; covers rotated speed vector and bearing vector.
  localparam int unsigned CW = 48;
  // Angle accumulator width (2^-24 rad units).
  localparam int unsigned ZW = 32;

  localparam logic [16:0] Pi13     = 17'd25736;
  localparam logic [16:0] TwoPi13  = 17'd51472;
  localparam logic signed [ZW-1:0] Pi24     = 32'sd52707179;
  localparam logic signed [ZW-1:0] TwoPi24  = 32'sd105414357;
  localparam logic signed [ZW-1:0] HalfPi24 = 32'sd26353589;
  localparam logic [15:0] TenthQ16 = 16'd6554;
  localparam logic [15:0] InvKQ16  = 16'd39797;
  localparam logic [LinW-1:0] LinMax = 13'd4096;

  localparam logic [CfgIdxW-1:0] RegLinGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAngGain  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCatchThr = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHorizon  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,      // speed vector and pre-scale
    ST_ROT_INIT,
    ST_ROT,
    ST_PRED,     // apply horizon
    ST_DELTA,
    ST_SQRT,
    ST_VEC_INIT,
    ST_VEC,
    ST_ERR,
    ST_CMD,
    ST_OUT
  } phc_state_e;

  typedef struct packed {
    logic             start;
    logic             vectoring;   // 0 rotate (z drives), 1 vectoring (y drives)
  } cordic_ctl_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 32'sd13176795;
      5'd1:  r = 32'sd7778716;
      5'd2:  r = 32'sd4110060;
      5'd3:  r = 32'sd2086331;
      5'd4:  r = 32'sd1047214;
      5'd5:  r = 32'sd524117;
      5'd6:  r = 32'sd262123;
      5'd7:  r = 32'sd131069;
      5'd8:  r = 32'sd65536;
      5'd9:  r = 32'sd32768;
      5'd10: r = 32'sd16384;
      5'd11: r = 32'sd8192;
      5'd12: r = 32'sd4096;
      5'd13: r = 32'sd2048;
      5'd14: r = 32'sd1024;
      5'd15: r = 32'sd512;
      5'd16: r = 32'sd256;
      5'd17: r = 32'sd128;
      5'd18: r = 32'sd64;
      5'd19: r = 32'sd32;
      5'd20: r = 32'sd16;
      5'd21: r = 32'sd8;
      5'd22: r = 32'sd4;
      5'd23: r = 32'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/phc_if.sv @@
// ----------------------------------------------------------------------------
// Pursuit controller channel interfaces
// Valid/ready channels for pose items and command results.
// ----------------------------------------------------------------------------
interface phc_pose_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [phc_pkg::PosW-1:0]       pos_x;
  logic signed [phc_pkg::PosW-1:0]       pos_y;
  logic signed [phc_pkg::AngW-1:0]       heading;
  logic signed [phc_pkg::PosW-1:0]       forward_speed;
  logic signed [phc_pkg::PosW-1:0]       turn_rate;
  modport source (output valid, mode, pos_x, pos_y, heading, forward_speed, turn_rate,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, heading, forward_speed, turn_rate,
                output ready);
endinterface

interface phc_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic        [phc_pkg::LinW-1:0]       linear_command;
  logic signed [phc_pkg::PosW-1:0]       angular_command;
  logic                                  reset_request;
  modport source (output valid, linear_command, angular_command, reset_request,
                  input ready);
  modport sink (input valid, linear_command, angular_command, reset_request,
                output ready);
endinterface

@@ hw/rtl/phc_cordic.sv @@
// ----------------------------------------------------------------------------
// phc_cordic
// Shared CORDIC unit, one micro-rotation per cycle, rotate or vectoring mode.
// ----------------------------------------------------------------------------
module phc_cordic #(
  parameter int unsigned CordicSteps = phc_pkg::CordicStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  phc_pkg::cordic_ctl_t              ctl_i,
  input  logic signed [phc_pkg::CW-1:0]     x_i,
  input  logic signed [phc_pkg::CW-1:0]     y_i,
  input  logic signed [phc_pkg::ZW-1:0]     z_i,
  output logic signed [phc_pkg::CW-1:0]     x_o,
  output logic signed [phc_pkg::CW-1:0]     y_o,
  output logic signed [phc_pkg::ZW-1:0]     z_o,
  output logic                              done_o
);
  localparam int unsigned Steps = (CordicSteps < phc_pkg::CordicStepsMax) ?
                                  CordicSteps : phc_pkg::CordicStepsMax;

  logic signed [phc_pkg::CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [phc_pkg::ZW-1:0] z_q, z_d;
  logic [4:0] it_q, it_d;
  logic       busy_q, busy_d, vec_q, vec_d;
  logic       dir;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q; busy_d = busy_q; vec_d = vec_q;
    dir = vec_q ? ~y_q[phc_pkg::CW-1] : ~z_q[phc_pkg::ZW-1];
    if (ctl_i.start) begin
      x_d = x_i; y_d = y_i; z_d = z_i; it_d = '0; busy_d = 1'b1; vec_d = ctl_i.vectoring;
    end else if (busy_q) begin
      // vectoring: y>=0 rotates clockwise; rotate: z>=0 counter-clockwise
      if (!(vec_q ^ dir)) begin
        x_d = x_q + (y_q >>> it_q);
        y_d = y_q - (x_q >>> it_q);
      end else begin
        x_d = x_q - (y_q >>> it_q);
        y_d = y_q + (x_q >>> it_q);
      end
      if (vec_q ? dir : ~dir) z_d = z_q + phc_pkg::atan_lut(it_q);
      else                    z_d = z_q - phc_pkg::atan_lut(it_q);
      it_d = it_q + 5'd1;
      if (it_q == 5'(Steps - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
      vec_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      it_q   <= it_d;
      vec_q  <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign done_o = ~busy_q & ~ctl_i.start;
endmodule

@@ hw/rtl/pursuit_heading_controller.sv @@
// ----------------------------------------------------------------------------
// pursuit_heading_controller
// Proportional pursuit controller with target prediction.
// ----------------------------------------------------------------------------
// Usage:
//   pose_in carries pose items. mode 0 stores the chaser pose and produces no
//   result. mode 1 is a target pose: the block predicts the target ahead by
//   the horizon, measures distance and bearing and sends one transfer on
//   cmd_out with linear/angular commands and a catch flag.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) land the same cycle.
// Sequence / throughput:
//   Own-pose item: accepted and stored, ready again next cycle.
//   Target item: pre-scale of the speed vector, a CORDIC run for the speed
//   rotation, horizon prediction and deltas, a CORDIC run for the bearing,
//   25 square-root steps, then error and commands into the output
//   register; pose_in is ready again the cycle after the result transfer,
//   so a new target item is taken only once the last result has gone.
// Reset: registers take their default values, own pose is zero, no output.
// Stall: a finished result waits in the output register until taken; no
//   new item is accepted until then.
// ----------------------------------------------------------------------------
module pursuit_heading_controller #(
  parameter int unsigned CordicSteps = phc_pkg::CordicStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [phc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [phc_pkg::CfgDataW-1:0]      cfg_data_i,
  phc_pose_if.sink                          pose_in,
  phc_cmd_if.source                         cmd_out
);
  localparam int unsigned CW = phc_pkg::CW;
  localparam int unsigned ZW = phc_pkg::ZW;
  // distance: 25-bit root of a radicand below 2^50
  localparam int unsigned RootW = 25;
  localparam int unsigned RemW  = 2 * RootW;
  localparam int unsigned TtW   = RemW + 2;

  phc_pkg::phc_state_e st_q, st_d;

  logic [15:0] lin_gain_q, ang_gain_q, thr_q, hor_q;
  logic signed [15:0] own_x_q, own_y_q;
  logic [15:0] own_h_q;

  // item latch
  logic signed [15:0] px_q, py_q, spd_q, rate_q;
  logic [15:0] th_q;

  // work registers
  logic signed [CW-1:0] a_q, a_d, b_q, b_d;
  logic [RemW-1:0] rem_q, rem_d;       // radicand
  logic [RootW-1:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic signed [17:0] err_q, err_d;
  logic [phc_pkg::LinW-1:0] lin_q, lin_d;
  logic signed [15:0] ang_q, ang_d;
  logic rr_q, rr_d;
  logic ovalid_q;

  phc_pkg::cordic_ctl_t cctl;
  logic signed [CW-1:0] cx_in, cy_in, cx, cy;
  logic signed [ZW-1:0] cz_in, cz;
  logic cdone;

  phc_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl), .x_i(cx_in), .y_i(cy_in), .z_i(cz_in),
    .x_o(cx), .y_o(cy), .z_o(cz), .done_o(cdone)
  );

  wire in_xfer = pose_in.valid & pose_in.ready;
  assign pose_in.ready = (st_q == phc_pkg::ST_IDLE) & ~ovalid_q;

  function automatic logic [15:0] fold(input logic signed [15:0] h);
    logic [16:0] s;
    s = 17'(h) + phc_pkg::TwoPi13;
    return h[15] ? s[15:0] : h;
  endfunction

  // round-half-up arithmetic shift helper on 64 bits
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  // shared multiply operands, one product per cycle
  logic signed [31:0]   m_a;
  logic signed [17:0]   m_b;
  logic signed [63:0]   m_p;
  assign m_p = 64'(m_a) * 64'(m_b);

  // shared squarer: dx in ST_DELTA, dy in ST_VEC_INIT
  logic signed [RootW-1:0] sq_op;
  logic signed [RemW-1:0]  sq;
  assign sq_op = (st_q == phc_pkg::ST_VEC_INIT) ? b_q[RootW-1:0] : a_q[RootW-1:0];
  assign sq = RemW'(sq_op) * RemW'(sq_op);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      phc_pkg::ST_IDLE:     if (in_xfer && pose_in.mode) st_d = phc_pkg::ST_PRE;
      phc_pkg::ST_PRE:      if (cnt_q == 5'd1) st_d = phc_pkg::ST_ROT_INIT;
      phc_pkg::ST_ROT_INIT: st_d = phc_pkg::ST_ROT;
      phc_pkg::ST_ROT:      if (cdone) st_d = phc_pkg::ST_PRED;
      phc_pkg::ST_PRED:     if (cnt_q == 5'd1) st_d = phc_pkg::ST_DELTA;
      phc_pkg::ST_DELTA:    if (cnt_q == 5'd1) st_d = phc_pkg::ST_VEC_INIT;
      phc_pkg::ST_VEC_INIT: st_d = phc_pkg::ST_VEC;
      phc_pkg::ST_VEC:      if (cdone) st_d = phc_pkg::ST_SQRT;
      phc_pkg::ST_SQRT:     if (cnt_q == 5'(RootW - 1)) st_d = phc_pkg::ST_ERR;
      phc_pkg::ST_ERR:      st_d = phc_pkg::ST_CMD;
      phc_pkg::ST_CMD:      if (cnt_q == 5'd1) st_d = phc_pkg::ST_OUT;
      phc_pkg::ST_OUT:      st_d = phc_pkg::ST_IDLE;
      default:              st_d = phc_pkg::ST_IDLE;
    endcase
  end

  // datapath
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] bz;
  logic signed [17:0] brg;
  logic signed [18:0] e0;
  logic signed [63:0] t64;
  logic [4:0]         sq_k;
  logic [TtW-1:0]     sq_tt;
  always_comb begin
    a_d = a_q; b_d = b_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q + 5'd1;
    err_d = err_q; lin_d = lin_q; ang_d = ang_q; rr_d = rr_q;
    cctl = '0; cx_in = a_q; cy_in = b_q; cz_in = '0;
    m_a = '0; m_b = '0; zr = '0; bz = '0; brg = '0; e0 = '0; t64 = '0;
    sq_k = '0; sq_tt = '0;
    if (st_d != st_q) cnt_d = '0;
    case (st_q)
      phc_pkg::ST_PRE: begin
        if (cnt_q == 5'd0) begin
          // vx = spd*256 * invK ; vy = round(rate*0.1*256)
          m_a = 32'(spd_q) <<< 8; m_b = 18'(phc_pkg::InvKQ16);
          a_d = CW'(rnd(m_p, 16));
          t64 = 64'(rate_q) * 64'(phc_pkg::TenthQ16);
          b_d = CW'(rnd(t64, 8));
        end else begin
          m_a = 32'(b_q); m_b = 18'(phc_pkg::InvKQ16);
          b_d = CW'(rnd(m_p, 16));
        end
      end
      phc_pkg::ST_ROT_INIT: begin
        zr = ZW'(th_q) <<< 11;
        if (zr > phc_pkg::Pi24) zr = zr - phc_pkg::TwoPi24;
        cctl.start = 1'b1;
        if (zr > phc_pkg::HalfPi24) begin
          cx_in = -b_q; cy_in = a_q; zr = zr - phc_pkg::HalfPi24;
        end else if (zr < -phc_pkg::HalfPi24) begin
          cx_in = b_q; cy_in = -a_q; zr = zr + phc_pkg::HalfPi24;
        end
        cz_in = zr;
      end
      phc_pkg::ST_PRED: begin
        m_b = 18'(hor_q);
        if (cnt_q == 5'd0) begin
          m_a = 32'(cx); a_d = CW'(px_q) + CW'(rnd(m_p, 16));
        end else begin
          m_a = 32'(cy); b_d = CW'(py_q) + CW'(rnd(m_p, 16));
        end
      end
      phc_pkg::ST_DELTA: begin
        if (cnt_q == 5'd0) begin
          a_d = a_q - CW'(own_x_q); b_d = b_q - CW'(own_y_q);
        end else begin
          rem_d = $unsigned(sq);
        end
      end
      phc_pkg::ST_VEC_INIT: begin
        rem_d = rem_q + $unsigned(sq);
        root_d = '0;
        cctl.start = 1'b1; cctl.vectoring = 1'b1;
        cx_in = a_q <<< 8; cy_in = b_q <<< 8;
        if (a_q[CW-1]) begin
          if (!b_q[CW-1]) begin
            cx_in = b_q <<< 8; cy_in = -(a_q <<< 8); cz_in = phc_pkg::HalfPi24;
          end else begin
            cx_in = -(b_q <<< 8); cy_in = a_q <<< 8; cz_in = -phc_pkg::HalfPi24;
          end
        end
      end
      phc_pkg::ST_SQRT: begin
        // restoring root, one result bit per cycle, MSB first:
        // subtract (4r+1)<<2k when it fits
        sq_k  = 5'(RootW - 1) - cnt_q;
        sq_tt = ((TtW'(root_q) << 2) | TtW'(1)) << {sq_k, 1'b0};
        if (TtW'(rem_q) >= sq_tt) begin
          rem_d  = rem_q - sq_tt[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          root_d = {root_q[RootW-2:0], 1'b0};
        end
      end
      phc_pkg::ST_ERR: begin
        bz = (a_q == '0 && b_q == '0) ? '0 : cz;
        brg = 18'((bz + 32'sd1024) >>> 11);
        if (brg[17]) brg = brg + 18'(phc_pkg::TwoPi13);
        e0 = 19'(brg) - 19'(own_h_q);
        if (e0 > 19'sd25736) e0 = e0 - 19'sd51472;
        else if (e0 < -19'sd25736) e0 = e0 + 19'sd51472;
        err_d = 18'(e0);
        rr_d = (root_q < RootW'(thr_q));
      end
      phc_pkg::ST_CMD: begin
        if (cnt_q == 5'd0) begin
          m_a = 32'(root_q); m_b = 18'(lin_gain_q);
          t64 = rnd(m_p, 8);
          lin_d = (t64 > 64'sd4096) ? phc_pkg::LinMax : t64[phc_pkg::LinW-1:0];
        end else begin
          m_a = 32'(err_q); m_b = 18'(ang_gain_q);
          t64 = rnd(m_p, 11);
          if (t64 > 64'sd32767) ang_d = 16'sh7fff;
          else if (t64 < -64'sd32768) ang_d = 16'sh8000;
          else ang_d = 16'(t64);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= phc_pkg::ST_IDLE; cnt_q <= '0; ovalid_q <= 1'b0;
      lin_gain_q <= 16'd256; ang_gain_q <= 16'd256; thr_q <= 16'd512; hor_q <= '0;
      own_x_q <= '0; own_y_q <= '0; own_h_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
      if (st_q == phc_pkg::ST_OUT) ovalid_q <= 1'b1;
      else if (cmd_out.ready) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          phc_pkg::RegLinGain:  lin_gain_q <= cfg_data_i;
          phc_pkg::RegAngGain:  ang_gain_q <= cfg_data_i;
          phc_pkg::RegCatchThr: thr_q <= cfg_data_i;
          phc_pkg::RegHorizon:  hor_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer && !pose_in.mode) begin
        own_x_q <= pose_in.pos_x; own_y_q <= pose_in.pos_y;
        own_h_q <= fold(pose_in.heading);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q <= pose_in.pos_x; py_q <= pose_in.pos_y; th_q <= fold(pose_in.heading);
      spd_q <= pose_in.forward_speed; rate_q <= pose_in.turn_rate;
    end
    a_q <= a_d; b_q <= b_d; rem_q <= rem_d; root_q <= root_d;
    err_q <= err_d; lin_q <= lin_d; ang_q <= ang_d; rr_q <= rr_d;
  end

  assign cmd_out.valid           = ovalid_q;
  assign cmd_out.linear_command  = lin_q;
  assign cmd_out.angular_command = ang_q;
  assign cmd_out.reset_request   = rr_q;
endmodule

@@ hw/rtl/phc_checker.sv @@
// ----------------------------------------------------------------------------
// phc_port_checks
// Port-level checks of the pursuit controller.
// ----------------------------------------------------------------------------
module phc_port_checks (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [phc_pkg::LinW-1:0]   lin
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_lin_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> lin <= phc_pkg::LinMax) else $error("linear above clamp");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result right after accept");
endmodule

bind pursuit_heading_controller phc_port_checks u_phc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(pose_in.valid), .in_ready(pose_in.ready),
  .out_valid(cmd_out.valid), .out_ready(cmd_out.ready), .lin(cmd_out.linear_command)
);

@@ tb/phc_checker.sv @@
// ----------------------------------------------------------------------------
// phc_checker
// Watches the pose and command channels and the register port. It predicts
// each command from its own pursuit-law model and compares it in order.
// ----------------------------------------------------------------------------
module phc_checker #(
  parameter int unsigned CordicSteps = phc_pkg::CordicStepsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [phc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [phc_pkg::CfgDataW-1:0] cfg_data_i,
  phc_pose_if                          pose,
  phc_cmd_if                           cmd,
  output int                           fail_cnt_o,
  output int                           pending_o,
  output int                           cmd_cnt_o,
  output int                           catch_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [phc_pkg::LinW-1:0]        lin;
    logic signed [phc_pkg::PosW-1:0] ang;
    logic                            catch_flag;
  } steer_cmd_t;

  localparam longint Pi13L = 25736;
  localparam longint TwoPi13L = 51472;
  localparam longint Pi24L = 52707179;
  localparam longint TwoPi24L = 105414357;
  localparam longint HalfPi24L = 26353589;

  // arctangent of 2^-i in 2^-24 rad
  localparam longint AtanQ24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic [15:0] lin_gain, ang_gain, catch_thr, horizon;
  longint      chaser_x, chaser_y, chaser_hdg;
  steer_cmd_t  cmd_q[$];

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint fold_angle(longint h);
    return (h < 0) ? h + TwoPi13L : h;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic steer_cmd_t steer_command(longint px, longint py, longint hd,
                                               longint spd, longint rate);
    steer_cmd_t r;
    longint vx, vy, z, t, nx, ny, tx, ty, dx, dy, bx, by, bz, lin, ang;
    longint bearing, err;
    longint unsigned span;
    vx = spd * 256;
    vy = rnd_shift(rate * 6554, 8);
    vx = rnd_shift(vx * 39797, 16);
    vy = rnd_shift(vy * 39797, 16);
    // rotate the speed vector through the target heading
    z = fold_angle(hd) * 2048;
    if (z > Pi24L) z -= TwoPi24L;
    if (z > HalfPi24L) begin
      t = vx; vx = -vy; vy = t; z -= HalfPi24L;
    end else if (z < -HalfPi24L) begin
      t = vx; vx = vy; vy = -t; z += HalfPi24L;
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      if (z >= 0) begin
        nx = vx - (vy >>> i); ny = vy + (vx >>> i); z -= AtanQ24[i];
      end else begin
        nx = vx + (vy >>> i); ny = vy - (vx >>> i); z += AtanQ24[i];
      end
      vx = nx; vy = ny;
    end
    tx = px + rnd_shift(vx * longint'(horizon), 16);
    ty = py + rnd_shift(vy * longint'(horizon), 16);
    dx = tx - chaser_x;
    dy = ty - chaser_y;
    span = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    // bearing by vectoring
    bx = dx * 256; by = dy * 256; bz = 0;
    if (bx != 0 || by != 0) begin
      if (bx < 0) begin
        if (by >= 0) begin
          t = bx; bx = by; by = -t; bz = HalfPi24L;
        end else begin
          t = bx; bx = -by; by = t; bz = -HalfPi24L;
        end
      end
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        if (by >= 0) begin
          nx = bx + (by >>> i); ny = by - (bx >>> i); bz += AtanQ24[i];
        end else begin
          nx = bx - (by >>> i); ny = by + (bx >>> i); bz -= AtanQ24[i];
        end
        bx = nx; by = ny;
      end
    end
    bearing = fold_angle(rnd_shift(bz, 11));
    err = bearing - chaser_hdg;
    if (err > Pi13L) err -= TwoPi13L;
    else if (err < -Pi13L) err += TwoPi13L;
    lin = rnd_shift(longint'(lin_gain) * longint'(span), 8);
    if (lin > 4096) lin = 4096;
    ang = rnd_shift(longint'(ang_gain) * err, 11);
    if (ang > 32767) ang = 32767;
    if (ang < -32768) ang = -32768;
    r.lin = lin[phc_pkg::LinW-1:0];
    r.ang = ang[15:0];
    r.catch_flag = (span < longint'(catch_thr));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    steer_cmd_t exp_cmd;
    if (!rst_ni) begin
      lin_gain <= 16'd256;
      ang_gain <= 16'd256;
      catch_thr <= 16'd512;
      horizon <= 16'd0;
      chaser_x = 0;
      chaser_y = 0;
      chaser_hdg = 0;
      cmd_q.delete();
      fail_cnt_o <= 0;
      cmd_cnt_o <= 0;
      catch_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          phc_pkg::RegLinGain:  lin_gain <= cfg_data_i;
          phc_pkg::RegAngGain:  ang_gain <= cfg_data_i;
          phc_pkg::RegCatchThr: catch_thr <= cfg_data_i;
          phc_pkg::RegHorizon:  horizon <= cfg_data_i;
          default: ;
        endcase
      end
      if (pose.valid && pose.ready) begin
        if (!pose.mode) begin
          chaser_x = longint'(pose.pos_x);
          chaser_y = longint'(pose.pos_y);
          chaser_hdg = fold_angle(longint'(pose.heading));
        end else begin
          cmd_q.push_back(steer_command(longint'(pose.pos_x), longint'(pose.pos_y),
                                        longint'(pose.heading),
                                        longint'(pose.forward_speed),
                                        longint'(pose.turn_rate)));
        end
      end
      if (cmd.valid && cmd.ready) begin
        cmd_cnt_o <= cmd_cnt_o + 1;
        if (cmd.reset_request) catch_cnt_o <= catch_cnt_o + 1;
        if (cmd_q.size() == 0) begin
          $display("%0t: command transfer with nothing expected", $time);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_cmd = cmd_q.pop_front();
          if (cmd.linear_command !== exp_cmd.lin ||
              cmd.angular_command !== exp_cmd.ang ||
              cmd.reset_request !== exp_cmd.catch_flag) begin
            $display("%0t: mismatch lin exp %0d got %0d, ang exp %0d got %0d,",
                     $time, exp_cmd.lin, cmd.linear_command, exp_cmd.ang,
                     cmd.angular_command);
            $display("%0t:   rr exp %0b got %0b",
                     $time, exp_cmd.catch_flag, cmd.reset_request);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = cmd_q.size();

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives pose items and register settings into the pursuit controller with
// bursty traffic and a stalling command receiver; the checker does the
// comparison and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phc_pkg::*;

  localparam int unsigned Steps = CordicStepsDef;
  localparam int WatchLimit = 5000;  // idle cycles before giving up
  localparam int SettleCycles = 100; // > one target item's latency

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_cnt, pending, cmd_cnt, catch_cnt;
  int                  own_cnt, target_cnt;
  int                  burst_left;
  int                  idle_cycles;
  int unsigned         rx_cyc;

  phc_pose_if pose ();
  phc_cmd_if  cmd ();

  pursuit_heading_controller #(.CordicSteps(Steps)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pose_in    (pose),
    .cmd_out    (cmd)
  );

  phc_checker #(.CordicSteps(Steps)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pose        (pose),
    .cmd         (cmd),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .cmd_cnt_o   (cmd_cnt),
    .catch_cnt_o (catch_cnt)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: stall style changes with bits 9:8 of the cycle counter so stalls
  // land on every phase of the block's work; one style never stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cyc <= 0;
      cmd.ready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      case (rx_cyc[9:8])
        2'd0: cmd.ready <= 1'b1;
        2'd1: cmd.ready <= $urandom_range(0, 1);
        2'd2: cmd.ready <= (rx_cyc[5:0] >= 6'd40);  // long stall windows
        default: cmd.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Watchdog: cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (pose.valid && pose.ready) || (cmd.valid && cmd.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: watchdog expired, %0d commands still expected", $time, pending);
        $display("FAIL");
        $finish;
      end
    end
  end

  // One pose transfer. Valid stays high between items of a burst; a gap is
  // taken only when a burst ends.
  task automatic send_pose(input logic md, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] hdg, input logic [15:0] spd,
                           input logic [15:0] rate);
    int gap;
    pose.valid <= 1'b1;
    pose.mode <= md;
    pose.pos_x <= x;
    pose.pos_y <= y;
    pose.heading <= hdg;
    pose.forward_speed <= spd;
    pose.turn_rate <= rate;
    @(posedge clk_i);
    while (!pose.ready) @(posedge clk_i);
    if (md) target_cnt++;
    else own_cnt++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // every few bursts run back to back
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        pose.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off until every command is back and the block has gone quiet.
  task automatic drain();
    pose.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] lg, input logic [15:0] ag,
                            input logic [15:0] thr, input logic [15:0] hz);
    logic [15:0] vals [4];
    vals = '{lg, ag, thr, hz};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly target items near the chaser so distances are
  // small enough to catch, with full-range noise mixed in.
  task automatic random_items(input int n);
    logic [15:0] ox, oy, x, y, h, s, r;
    ox = 16'h0;
    oy = 16'h0;
    for (int k = 0; k < n; k++) begin
      h = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
          16'($signed($urandom_range(0, 51472)) - 25736);
      if ($urandom_range(0, 3) == 0) begin
        ox = 16'($urandom);
        oy = 16'($urandom);
        send_pose(1'b0, ox, oy, h, 16'($urandom), 16'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            x = 16'($urandom);
            y = 16'($urandom);
          end
          1: begin
            x = ox + 16'($signed($urandom_range(0, 1024)) - 512);
            y = oy + 16'($signed($urandom_range(0, 1024)) - 512);
          end
          default: begin
            x = ox + 16'($signed($urandom_range(0, 16384)) - 8192);
            y = oy + 16'($signed($urandom_range(0, 16384)) - 8192);
          end
        endcase
        s = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
            16'($signed($urandom_range(0, 4096)) - 2048);
        r = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
            16'($signed($urandom_range(0, 4096)) - 2048);
        send_pose(1'b1, x, y, h, s, r);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    pose.valid = 1'b0;
    pose.mode = 1'b0;
    pose.pos_x = '0;
    pose.pos_y = '0;
    pose.heading = '0;
    pose.forward_speed = '0;
    pose.turn_rate = '0;
    own_cnt = 0;
    target_cnt = 0;
    burst_left = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values
    send_pose(1'b1, 16'd1024, 16'd0, 16'd0, 16'd0, 16'd0);           // target ahead, chaser at origin from reset
    send_pose(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);              // target on chaser
    send_pose(1'b1, -16'sd1024, 16'd0, 16'd0, 16'd0, 16'd0);         // error of pi
    send_pose(1'b1, 16'd0, -16'sd2048, 16'd0, 16'd0, 16'd0);
    send_pose(1'b1, 16'd300, 16'd100, 16'd0, 16'd0, 16'd0);          // inside catch radius
    send_pose(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_pose(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_pose(1'b0, 16'd0, 16'd0, -16'sd25736, 16'd0, 16'd0);        // negative heading folded
    send_pose(1'b1, -16'sd1024, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pose(1'b1, 16'd1024, 16'd5, 16'd0, 16'd0, 16'd0);
    send_pose(1'b0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000); // heading past pi
    send_pose(1'b1, 16'sh7fff, 16'sh8000, 16'd25736, 16'd0, 16'd0);
    send_pose(1'b1, 16'sh8000, 16'sh7fff, -16'sd25736, 16'd0, 16'd0);
    drain();

    // Horizon on: prediction along heading and sideways, extreme speeds
    write_regs(16'd256, 16'd256, 16'd512, 16'd256);
    send_pose(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pose(1'b1, 16'd0, 16'd0, 16'd0, 16'd1024, 16'd0);
    send_pose(1'b1, 16'd0, 16'd0, 16'd12868, 16'd0, 16'd1024);
    send_pose(1'b1, 16'd0, 16'd0, -16'sd12868, 16'sh7fff, 16'sh7fff);
    send_pose(1'b1, 16'd0, 16'd0, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_pose(1'b1, 16'd100, -16'sd100, 16'd25736, -16'sd1024, 16'd0);
    drain();

    random_items(100);                // reset-like gains with horizon
    drain();
    write_regs(16'd0, 16'd0, 16'd0, 16'd0);
    random_items(100);
    drain();
    write_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    random_items(100);
    drain();
    write_regs(16'd64, 16'd2048, 16'd4096, 16'd32);
    random_items(100);
    drain();
    write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 1024)));
    random_items(100);
    drain();
    write_regs(16'd256, 16'd256, 16'd512, 16'd0);
    random_items(100);
    drain();

    $display("Ran %0d own-pose and %0d target items over 7 register settings;",
             own_cnt, target_cnt);
    $display("%0d commands checked, %0d with a catch request.", cmd_cnt, catch_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/phc_pkg.sv
hw/rtl/phc_if.sv
hw/rtl/phc_cordic.sv
hw/rtl/pursuit_heading_controller.sv
hw/rtl/phc_checker.sv
tb/phc_checker.sv
tb/tb.sv
